### hdl/scf_pkg.sv
// shared types and codes for the session controller
package scf_pkg;

	localparam int TIME_BITS_DEF = 24;
	localparam int TICK_W = 16;
	localparam int DUR_W = 24;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_CONN   = 2'd1,
		ST_ACTIVE = 2'd2,
		ST_ERROR  = 2'd3
	} main_state_t;

	typedef enum logic [1:0] {
		SUB_LISTEN = 2'd0,
		SUB_THINK  = 2'd1,
		SUB_SPEAK  = 2'd2
	} sub_state_t;

	typedef enum logic [1:0] {
		PTT_NONE    = 2'd0,
		PTT_PRESS   = 2'd1,
		PTT_RELEASE = 2'd2
	} ptt_t;

	typedef enum logic [1:0] {
		CFG_TICK_PERIOD  = 2'd0,
		CFG_BACKOFF      = 2'd1,
		CFG_IDLE_TIMEOUT = 2'd2,
		CFG_LONG_PRESS   = 2'd3
	} cfg_idx_t;

	localparam logic [3:0] EV_TICK       = 4'd0;
	localparam logic [3:0] EV_ACTIVITY   = 4'd1;
	localparam logic [3:0] EV_WAKE       = 4'd2;
	localparam logic [3:0] EV_PRESS      = 4'd3;
	localparam logic [3:0] EV_RELEASE    = 4'd4;
	localparam logic [3:0] EV_NET_READY  = 4'd5;
	localparam logic [3:0] EV_NET_LOST   = 4'd6;
	localparam logic [3:0] EV_LINK_UP    = 4'd7;
	localparam logic [3:0] EV_LINK_FAIL  = 4'd8;
	localparam logic [3:0] EV_SPEECH_ON  = 4'd9;
	localparam logic [3:0] EV_SPEECH_OFF = 4'd10;
	localparam logic [3:0] EV_REPLY_TEXT = 4'd11;
	localparam logic [3:0] EV_COMPLETED  = 4'd12;

	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 16'd10;
	localparam logic [DUR_W-1:0] BACKOFF_RST = 24'd5000;
	localparam logic [DUR_W-1:0] IDLE_TIMEOUT_RST = 24'd30000;
	localparam logic [DUR_W-1:0] LONG_PRESS_RST = 24'd1000;

	typedef struct packed {
		logic [3:0] kind;
		logic       audio_start_ok;
	} item_t;

	typedef struct packed {
		main_state_t main_state;
		sub_state_t  sub_state;
		logic        session_mode;
		logic        request_start;
		logic        stop_session;
		logic        audio_complete;
		ptt_t        ptt_command;
		logic        indicator_update;
	} result_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_period_ms;
		logic [DUR_W-1:0]  backoff_ms;
		logic [DUR_W-1:0]  idle_timeout_ms;
		logic [DUR_W-1:0]  long_press_ms;
	} cfg_t;

endpackage

### hdl/session_controller_fsm_top.sv
// session controller: input register, state update, result register
// an accepted item passes the input register, then the result register
// throughput: one item per cycle unless stalled; the state update for an item is a single registered step
// a full result register with out_ready low stalls the input register, then in_ready
// reset: asynchronous, active low; state idle/listening/voice, counters zero,
// configuration back to its defaults, both pipeline registers empty
module session_controller_fsm_top import scf_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_t            in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [DUR_W-1:0] cfg_data
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_next;
	cfg_t    cfg;
	logic    advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
		if (advance) res_s2 <= res_next;
	end

	scf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	scf_step #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_next)
	);

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

### hdl/scf_cfg_regs.sv
// configuration register file
module scf_cfg_regs import scf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  cfg_idx_t        wr_index,
	input  logic [DUR_W-1:0] wr_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_ms  <= TICK_PERIOD_RST;
			cfg_q.backoff_ms      <= BACKOFF_RST;
			cfg_q.idle_timeout_ms <= IDLE_TIMEOUT_RST;
			cfg_q.long_press_ms   <= LONG_PRESS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TICK_PERIOD:  cfg_q.tick_period_ms  <= wr_data[TICK_W-1:0];
				CFG_BACKOFF:      cfg_q.backoff_ms      <= wr_data;
				CFG_IDLE_TIMEOUT: cfg_q.idle_timeout_ms <= wr_data;
				CFG_LONG_PRESS:   cfg_q.long_press_ms   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/scf_step.sv
// session state machine: state registers and per-item update logic
module scf_step import scf_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

	main_state_t          state_q, state_d;
	sub_state_t           sub_q, sub_d;
	logic                 mode_q, mode_d;
	logic [TIME_BITS-1:0] idle_el_q, idle_el_d;
	logic [TIME_BITS-1:0] backoff_el_q, backoff_el_d;
	logic [TIME_BITS-1:0] press_el_q, press_el_d;
	logic                 held_q, held_d;
	logic                 await_q, await_d;
	logic [TIME_BITS-1:0] backoff_sum, idle_sum, press_sum;
	logic                 active;

	function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
			input logic [TICK_W-1:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + (TIME_BITS+1)'(b);
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	function automatic logic reached(input logic [TIME_BITS-1:0] el,
			input logic [DUR_W-1:0] lim);
		return CMP_W'(el) >= CMP_W'(lim);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sub_q        <= SUB_LISTEN;
			mode_q       <= 1'b0;
			idle_el_q    <= '0;
			backoff_el_q <= '0;
			press_el_q   <= '0;
			held_q       <= 1'b0;
			await_q      <= 1'b0;
		end else if (step) begin
			state_q      <= state_d;
			sub_q        <= sub_d;
			mode_q       <= mode_d;
			idle_el_q    <= idle_el_d;
			backoff_el_q <= backoff_el_d;
			press_el_q   <= press_el_d;
			held_q       <= held_d;
			await_q      <= await_d;
		end
	end

	assign backoff_sum = sat_add(backoff_el_q, cfg.tick_period_ms);
	assign idle_sum    = sat_add(idle_el_q, cfg.tick_period_ms);
	assign press_sum   = sat_add(press_el_q, cfg.tick_period_ms);
	assign active      = (state_q == ST_ACTIVE);

	always_comb begin
		state_d      = state_q;
		sub_d        = sub_q;
		mode_d       = mode_q;
		idle_el_d    = idle_el_q;
		backoff_el_d = backoff_el_q;
		press_el_d   = press_el_q;
		held_d       = held_q;
		await_d      = await_q;
		result       = '0;

		unique case (item.kind)
			EV_TICK: begin
				priority if (state_q == ST_ERROR) begin
					backoff_el_d = backoff_sum;
					if (reached(backoff_sum, cfg.backoff_ms)) begin
						state_d = ST_IDLE;
						backoff_el_d = '0;
						result.indicator_update = 1'b1;
					end
				end else if (active) begin
					idle_el_d = idle_sum;
					// idle_elapsed keeps the advanced value on timeout and is not cleared
					if (reached(idle_sum, cfg.idle_timeout_ms)) begin
						state_d = ST_IDLE;
						result.stop_session = 1'b1;
						result.indicator_update = 1'b1;
					end
				end else if (state_q == ST_IDLE && held_q) begin
					press_el_d = press_sum;
					if (reached(press_sum, cfg.long_press_ms)) begin
						state_d = ST_CONN;
						mode_d = 1'b1;
						await_d = 1'b1;
						press_el_d = '0;
						result.indicator_update = 1'b1;
						result.request_start = 1'b1;
					end
				end else begin
				end
			end
			EV_ACTIVITY: begin
				if (active) idle_el_d = '0;
			end
			EV_WAKE: begin
				if (state_q == ST_IDLE) begin
					state_d = ST_CONN;
					mode_d = 1'b0;
					await_d = 1'b0;
					result.indicator_update = 1'b1;
					result.request_start = 1'b1;
				end
			end
			EV_PRESS: begin
				held_d = 1'b1;
				press_el_d = '0;
				if (active && mode_q && !await_q) begin
					idle_el_d = '0;
					sub_d = SUB_LISTEN;
					result.ptt_command = PTT_PRESS;
					result.indicator_update = 1'b1;
				end
			end
			EV_RELEASE: begin
				held_d = 1'b0;
				press_el_d = '0;
				priority if (await_q) begin
					await_d = 1'b0;
					idle_el_d = '0;
				end else if (active && mode_q && held_q) begin
					idle_el_d = '0;
					sub_d = SUB_THINK;
					result.ptt_command = PTT_RELEASE;
					result.audio_complete = 1'b1;
					result.indicator_update = 1'b1;
				end else begin
				end
			end
			EV_NET_READY: begin
				if (state_q == ST_CONN) result.request_start = 1'b1;
			end
			EV_NET_LOST: begin
				if (state_q != ST_IDLE) begin
					state_d = ST_ERROR;
					backoff_el_d = '0;
					result.stop_session = 1'b1;
					result.indicator_update = 1'b1;
				end
			end
			EV_LINK_UP: begin
				if (item.audio_start_ok) begin
					state_d = ST_ACTIVE;
					sub_d = SUB_LISTEN;
					idle_el_d = '0;
				end else begin
					state_d = ST_ERROR;
					backoff_el_d = '0;
					result.stop_session = 1'b1;
				end
				result.indicator_update = 1'b1;
			end
			EV_LINK_FAIL: begin
				state_d = ST_ERROR;
				backoff_el_d = '0;
				await_d = 1'b0;
				result.stop_session = 1'b1;
				result.indicator_update = 1'b1;
			end
			EV_SPEECH_ON, EV_SPEECH_OFF, EV_REPLY_TEXT, EV_COMPLETED: begin
				if (active) begin
					priority if (item.kind == EV_SPEECH_OFF) sub_d = SUB_THINK;
					else if (item.kind == EV_REPLY_TEXT) sub_d = SUB_SPEAK;
					else sub_d = SUB_LISTEN;
					idle_el_d = '0;
					result.indicator_update = 1'b1;
				end
			end
			default: ;
		endcase

		result.main_state   = state_d;
		result.sub_state    = sub_d;
		result.session_mode = mode_d;
	end

endmodule
